/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// clocked check that also holds during reset
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed during reset");

`endif

/* rtl/cfrle_pkg.sv */
// ---------------------------------------------------------------------------
// cfrle_pkg
// types, constants and helpers of the case folding run-length encoder
// ---------------------------------------------------------------------------
package cfrle_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] len_t;

  // longest run before it is split, keeps the count a single digit
  localparam len_t  MaxRun    = 4'd9;
  localparam byte_t DigitZero = 8'h30;
  localparam byte_t UpperA    = 8'h41;
  localparam byte_t UpperZ    = 8'h5A;
  localparam byte_t CaseGap   = 8'h20;

  // most bytes a single request can produce
  localparam int unsigned MaxOut = 4;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);
  localparam int unsigned IdxW   = $clog2(MaxOut);

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [IdxW-1:0] idx_t;

  // upper-case letters map to lower case, every other byte stays as is
  function automatic byte_t fold_byte(input byte_t c);
    byte_t r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c + CaseGap;
    end
    return r;
  endfunction

  // ascii digit of a run length
  function automatic byte_t len_digit(input len_t n);
    return DigitZero + {4'd0, n};
  endfunction

endpackage

/* rtl/cfrle_in_if.sv */
// ---------------------------------------------------------------------------
// cfrle_in_if
// character channel: one raw byte with its end-of-string mark
// ---------------------------------------------------------------------------
interface cfrle_in_if import cfrle_pkg::*; ();

  logic  valid;
  logic  ready;
  byte_t char_in;
  logic  end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink   (input valid, input char_in, input end_of_string, output ready);

endinterface

/* rtl/cfrle_out_if.sv */
// ---------------------------------------------------------------------------
// cfrle_out_if
// encoded byte channel: one output byte with its last-of-request mark
// ---------------------------------------------------------------------------
interface cfrle_out_if import cfrle_pkg::*; ();

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);

endinterface

/* rtl/case_folding_run_length_encoder_unit.sv */
// ---------------------------------------------------------------------------
// case_folding_run_length_encoder_unit
// run-length encoder with case-insensitive letter matching
// ---------------------------------------------------------------------------
// usage:
//   in_i takes one character byte per request, end_of_string marks the last
//   one of a string. out_o gives the encoded bytes: the ascii length digit
//   of a run, then its lower-cased character. last_out marks the final byte
//   caused by one input request.
//   an accepted request's bytes wait in the pending buffer, then pass
//   through the output register to out_o.
//   throughput: a request that closes no run and ends no string is taken
//   every cycle while no bytes are pending. otherwise one byte leaves per
//   cycle while out_o is ready, and in_i is not ready again until the last
//   byte of the request leaves. the single output port sets this pace.
//   a byte held at a stalled out_o does not block in_i: up to four more
//   bytes are buffered behind it before in_i drops ready.
//   reset clears the open run and drops every buffered byte.
// ---------------------------------------------------------------------------
module case_folding_run_length_encoder_unit import cfrle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfrle_in_if.sink    in_i,
  cfrle_out_if.source out_o
);

  // run state
  byte_t run_sym_q, run_sym_d;
  len_t  run_len_q, run_len_d;
  logic  run_open_q, run_open_d;

  // bytes waiting behind the output register
  byte_t pend_q [MaxOut];
  byte_t pend_d [MaxOut];
  cnt_t  pend_cnt_q, pend_cnt_d;
  idx_t  head_q, head_d;

  // output register
  logic  out_vld_q;
  byte_t out_byte_q;
  logic  out_last_q;

  logic  in_acc;
  logic  move;
  byte_t c_fold;
  logic  match;
  logic  brk;
  len_t  new_len;
  byte_t new_sym;
  cnt_t  n_new;

  // handshake
  assign move         = (pend_cnt_q != '0) && (!out_vld_q || out_o.ready);
  assign in_i.ready   = (pend_cnt_q == '0) || ((pend_cnt_q == cnt_t'(1)) && move);
  assign in_acc       = in_i.valid && in_i.ready;
  assign out_o.valid    = out_vld_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last_out = out_last_q;

  // run tracking and byte generation
  always_comb begin
    c_fold  = fold_byte(in_i.char_in);
    match   = run_open_q && (c_fold == run_sym_q) && (run_len_q < MaxRun);
    brk     = run_open_q && !match;
    new_len = match ? (run_len_q + len_t'(1)) : len_t'(1);
    new_sym = match ? run_sym_q : c_fold;
    n_new   = (brk ? cnt_t'(2) : cnt_t'(0)) + (in_i.end_of_string ? cnt_t'(2) : cnt_t'(0));

    run_sym_d  = run_sym_q;
    run_len_d  = run_len_q;
    run_open_d = run_open_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    head_d     = head_q;

    // drain one byte into the output register
    if (move) begin
      pend_cnt_d = pend_cnt_q - cnt_t'(1);
      head_d     = head_q + idx_t'(1);
    end

    if (in_acc) begin
      if (brk) begin
        pend_d[0] = len_digit(run_len_q);
        pend_d[1] = run_sym_q;
        pend_d[2] = len_digit(new_len);
        pend_d[3] = new_sym;
      end else begin
        pend_d[0] = len_digit(new_len);
        pend_d[1] = new_sym;
      end
      pend_cnt_d = n_new;
      head_d     = '0;
      if (in_i.end_of_string) begin
        run_sym_d  = '0;
        run_len_d  = '0;
        run_open_d = 1'b0;
      end else begin
        run_sym_d  = new_sym;
        run_len_d  = new_len;
        run_open_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sym_q  <= '0;
      run_len_q  <= '0;
      run_open_q <= 1'b0;
      pend_cnt_q <= '0;
      head_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      run_sym_q  <= run_sym_d;
      run_len_q  <= run_len_d;
      run_open_q <= run_open_d;
      pend_cnt_q <= pend_cnt_d;
      head_q     <= head_d;
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (move) begin
      out_byte_q <= pend_q[head_q];
      out_last_q <= (pend_cnt_q == cnt_t'(1));
    end
  end

endmodule

/* rtl/cfrle_chk.sv */
// ---------------------------------------------------------------------------
// cfrle_chk
// port-level checks of the case folding run-length encoder
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfrle_chk import cfrle_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  in_eos_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input byte_t out_byte_i,
  input logic  out_last_i
);

  // a stalled byte holds
  `ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))

  // nothing is offered while in reset
  `ASSERT_RST(a_rst_idle, !rst_ni |-> !out_valid_i)

  // an accepted end of string is always followed by a byte offered on out_o
  `ASSERT_CLK(a_eos_flush, in_valid_i && in_ready_i && in_eos_i |-> ##2 out_valid_i)

  // the bytes of one request follow without gaps
  `ASSERT_CLK(a_no_gap, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)

endmodule

bind case_folding_run_length_encoder_unit cfrle_chk u_cfrle_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_eos_i   (in_i.end_of_string),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .out_last_i (out_o.last_out)
);
